[hw/rtl/sbct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbct_pkg;

    localparam int SBCT_SLOTS      = 16;
    localparam int SBCT_COORD_BITS = 16;
    localparam int SIDE_W          = 15;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_DETECT = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_ROW,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/sbct_box_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbct_box_ram #(
    parameter int SLOTS = sbct_pkg::SBCT_SLOTS,
    parameter int WIDTH = 2 * sbct_pkg::SBCT_COORD_BITS + sbct_pkg::SIDE_W
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(SLOTS)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

[hw/rtl/sbct_pair_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbct_pair_cmp #(
    parameter int COORD_BITS = sbct_pkg::SBCT_COORD_BITS
) (
    input  wire logic signed [COORD_BITS-1:0]      row_x,
    input  wire logic signed [COORD_BITS-1:0]      row_y,
    input  wire logic        [sbct_pkg::SIDE_W-1:0] row_side,
    input  wire logic signed [COORD_BITS-1:0]      cand_x,
    input  wire logic signed [COORD_BITS-1:0]      cand_y,
    input  wire logic        [sbct_pkg::SIDE_W-1:0] cand_side,
    output logic                                    hit
);

    localparam int CMP_W = (COORD_BITS + 1 > sbct_pkg::SIDE_W) ?
                           COORD_BITS + 1 : sbct_pkg::SIDE_W;

    // gap is exact in COORD_BITS+1 bits; the lower coordinate's side is the limit,
    // ties take the candidate's side
    function automatic logic axis_hit(
        input logic signed [COORD_BITS-1:0]       a,
        input logic signed [COORD_BITS-1:0]       b,
        input logic        [sbct_pkg::SIDE_W-1:0] sa,
        input logic        [sbct_pkg::SIDE_W-1:0] sb
    );
        logic signed [COORD_BITS:0]     diff;
        logic        [COORD_BITS:0]     gap;
        logic        [sbct_pkg::SIDE_W-1:0] lim;
        diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        gap  = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
        lim  = diff[COORD_BITS] ? sa : sb;
        return CMP_W'(gap) <= CMP_W'(lim);
    endfunction

    assign hit = axis_hit(row_x, cand_x, row_side, cand_side) &&
                 axis_hit(row_y, cand_y, row_side, cand_side);

endmodule

`default_nettype wire

[hw/rtl/square_box_collision_table.sv]
`timescale 1ns / 1ps
`default_nettype none

// Table of SLOTS square boxes kept in a two-read, one-write box memory, with
// occupancy flags in flip-flops. A command beat is taken on s_tuser (add,
// remove, move, detect). Add and remove finish on the command beat; move reads
// the box, then writes it back. Detect gives SLOTS result beats in slot order,
// the final one with tlast; each row of a live box above slot 0 scans its lower
// slots (row 0 and empty rows do not), because the memory's candidate port
// delivers one lower slot per cycle to the pair comparator. No new command is
// taken until every beat of the current one has been sent.
module square_box_collision_table #(
    parameter int SLOTS      = sbct_pkg::SBCT_SLOTS,
    parameter int COORD_BITS = sbct_pkg::SBCT_COORD_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // slot[3:0], pos_x[19:4], pos_y[35:20], extent[50:36], delta_x[66:51],
    // delta_y[82:67], zero pad
    input  wire logic [87:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // row_slot[3:0], row_live[4], hit_mask[20:5], live_count[25:21], zero pad
    output logic [31:0]      m_tdata,
    // status[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SIDE_W = sbct_pkg::SIDE_W;
    localparam int BOX_W  = 2 * COORD_BITS + SIDE_W;

    // input fields
    sbct_pkg::cmd_t     cmd;
    logic [3:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        extent;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;

    assign cmd     = sbct_pkg::cmd_t'(s_tuser);
    assign slot    = s_tdata[3:0];
    assign pos_x   = $signed(s_tdata[19:4]);
    assign pos_y   = $signed(s_tdata[35:20]);
    assign extent  = s_tdata[50:36];
    assign delta_x = $signed(s_tdata[66:51]);
    assign delta_y = $signed(s_tdata[82:67]);

    sbct_pkg::state_t state_reg, state_next;

    logic [SLOTS-1:0]  occ_reg, occ_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] row_reg, row_next;
    logic [SLOT_W-1:0] j_reg, j_next;

    logic [SLOT_W-1:0]  mv_slot_reg;
    logic signed [15:0] mv_dx_reg;
    logic signed [15:0] mv_dy_reg;

    logic [SLOTS-1:0]  mask_reg;
    logic              cmp_v_reg;
    logic [SLOT_W-1:0] cmp_j_reg;

    logic                out_valid_reg;
    sbct_pkg::status_t   out_status_reg;
    logic [3:0]          out_slot_reg;
    logic                out_live_reg;
    logic [15:0]         out_mask_reg;
    logic [4:0]          out_count_reg;
    logic                out_last_reg;

    // control
    logic              in_fire;
    logic              out_free;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic              occ_hit;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              row_scan;
    logic              row_last;

    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [BOX_W-1:0]  wr_data;
    logic [SLOT_W-1:0] rd_addr_a;
    logic [SLOT_W-1:0] rd_addr_b;
    logic [BOX_W-1:0]  rd_data_a;
    logic [BOX_W-1:0]  rd_data_b;
    logic              issue;
    logic              mask_clr;
    logic              pair_hit;

    logic                emit;
    sbct_pkg::status_t   em_status;
    logic [3:0]          em_slot;
    logic                em_live;
    logic [15:0]         em_mask;
    logic                em_last;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == sbct_pkg::ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign slot_ok  = (int'(slot) < SLOTS);
    assign slot_idx = SLOT_W'(slot);
    assign occ_hit  = slot_ok && occ_reg[slot_idx];
    assign row_scan = occ_reg[row_reg] && (row_reg != '0);
    assign row_last = (row_reg == SLOT_W'(SLOTS - 1));

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!occ_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbct_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (cmd)
                        sbct_pkg::CMD_MOVE:
                        begin
                            if (occ_hit)
                            begin
                                state_next = sbct_pkg::ST_MOVE;
                            end
                        end
                        sbct_pkg::CMD_DETECT: state_next = sbct_pkg::ST_ROW;
                        default:              state_next = sbct_pkg::ST_IDLE;
                    endcase
                end
            end
            sbct_pkg::ST_MOVE:
            begin
                if (out_free)
                begin
                    state_next = sbct_pkg::ST_IDLE;
                end
            end
            sbct_pkg::ST_ROW:
            begin
                if (!row_scan)
                begin
                    state_next = sbct_pkg::ST_EMIT;
                end
                else if (row_reg == SLOT_W'(1))
                begin
                    state_next = sbct_pkg::ST_DRAIN;
                end
                else
                begin
                    state_next = sbct_pkg::ST_SCAN;
                end
            end
            sbct_pkg::ST_SCAN:
            begin
                if (j_reg == row_reg - SLOT_W'(1))
                begin
                    state_next = sbct_pkg::ST_DRAIN;
                end
            end
            sbct_pkg::ST_DRAIN: state_next = sbct_pkg::ST_EMIT;
            sbct_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = row_last ? sbct_pkg::ST_IDLE : sbct_pkg::ST_ROW;
                end
            end
            default: state_next = sbct_pkg::ST_IDLE;
        endcase
    end

    // datapath control and result beats
    always_comb
    begin
        occ_next   = occ_reg;
        count_next = count_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        wr_en      = 1'b0;
        wr_addr    = free_idx;
        wr_data    = {extent, COORD_BITS'(pos_y), COORD_BITS'(pos_x)};
        rd_addr_a  = row_reg;
        rd_addr_b  = j_reg;
        issue      = 1'b0;
        mask_clr   = 1'b0;
        emit       = 1'b0;
        em_status  = sbct_pkg::STAT_OK;
        em_slot    = slot;
        em_live    = 1'b0;
        em_mask    = '0;
        em_last    = 1'b1;
        case (state_reg)
            sbct_pkg::ST_IDLE:
            begin
                rd_addr_a = slot_idx;
                if (in_fire)
                begin
                    case (cmd)
                        sbct_pkg::CMD_ADD:
                        begin
                            emit = 1'b1;
                            if (free_found)
                            begin
                                occ_next[free_idx] = 1'b1;
                                count_next         = count_reg + CNT_W'(1);
                                wr_en              = 1'b1;
                                em_slot            = 4'(free_idx);
                                em_live            = 1'b1;
                            end
                            else
                            begin
                                em_status = sbct_pkg::STAT_FULL;
                                em_slot   = '0;
                            end
                        end
                        sbct_pkg::CMD_REMOVE:
                        begin
                            emit = 1'b1;
                            if (occ_hit)
                            begin
                                occ_next[slot_idx] = 1'b0;
                                count_next         = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                em_status = sbct_pkg::STAT_EMPTY;
                            end
                        end
                        sbct_pkg::CMD_MOVE:
                        begin
                            if (!occ_hit)
                            begin
                                emit      = 1'b1;
                                em_status = sbct_pkg::STAT_EMPTY;
                            end
                        end
                        sbct_pkg::CMD_DETECT: row_next = '0;
                        default:              emit = 1'b0;
                    endcase
                end
            end
            sbct_pkg::ST_MOVE:
            begin
                rd_addr_a = mv_slot_reg;
                wr_addr   = mv_slot_reg;
                wr_data   = {rd_data_a[BOX_W-1 -: SIDE_W],
                             rd_data_a[2*COORD_BITS-1 -: COORD_BITS]
                                 + COORD_BITS'(mv_dy_reg),
                             rd_data_a[COORD_BITS-1:0] + COORD_BITS'(mv_dx_reg)};
                if (out_free)
                begin
                    wr_en   = 1'b1;
                    emit    = 1'b1;
                    em_slot = 4'(mv_slot_reg);
                    em_live = 1'b1;
                end
            end
            sbct_pkg::ST_ROW:
            begin
                mask_clr  = 1'b1;
                rd_addr_b = '0;
                if (row_scan)
                begin
                    issue  = 1'b1;
                    j_next = SLOT_W'(1);
                end
            end
            sbct_pkg::ST_SCAN:
            begin
                issue  = 1'b1;
                j_next = j_reg + SLOT_W'(1);
            end
            sbct_pkg::ST_DRAIN:
            begin
                issue = 1'b0;
            end
            sbct_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    em_slot  = 4'(row_reg);
                    em_live  = occ_reg[row_reg];
                    em_mask  = 16'(mask_reg);
                    em_last  = row_last;
                    row_next = row_reg + SLOT_W'(1);
                end
            end
            default: emit = 1'b0;
        endcase
    end

    sbct_box_ram #(
        .SLOTS (SLOTS),
        .WIDTH (BOX_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // row box on port a, lower candidate on port b
    sbct_pair_cmp #(
        .COORD_BITS (COORD_BITS)
    ) u_cmp (
        .row_x     ($signed(rd_data_a[COORD_BITS-1:0])),
        .row_y     ($signed(rd_data_a[2*COORD_BITS-1 -: COORD_BITS])),
        .row_side  (rd_data_a[BOX_W-1 -: SIDE_W]),
        .cand_x    ($signed(rd_data_b[COORD_BITS-1:0])),
        .cand_y    ($signed(rd_data_b[2*COORD_BITS-1 -: COORD_BITS])),
        .cand_side (rd_data_b[BOX_W-1 -: SIDE_W]),
        .hit       (pair_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbct_pkg::ST_IDLE;
            occ_reg       <= '0;
            count_reg     <= '0;
            row_reg       <= '0;
            j_reg         <= '0;
            cmp_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            count_reg <= count_next;
            row_reg   <= row_next;
            j_reg     <= j_next;
            cmp_v_reg <= issue;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_j_reg <= rd_addr_b;
        if (in_fire)
        begin
            mv_slot_reg <= slot_idx;
            mv_dx_reg   <= delta_x;
            mv_dy_reg   <= delta_y;
        end
        if (mask_clr)
        begin
            mask_reg <= '0;
        end
        else if (cmp_v_reg && pair_hit && occ_reg[cmp_j_reg])
        begin
            mask_reg[cmp_j_reg] <= 1'b1;
        end
        if (emit)
        begin
            out_status_reg <= em_status;
            out_slot_reg   <= em_slot;
            out_live_reg   <= em_live;
            out_mask_reg   <= em_mask;
            out_count_reg  <= 5'(count_next);
            out_last_reg   <= em_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_mask_reg, out_live_reg, out_slot_reg};

endmodule

`default_nettype wire

[hw/rtl/sbct_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbct_checker #(
    parameter int SLOTS = sbct_pkg::SBCT_SLOTS
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [87:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
    else $error("result beat changed while stalled");

    // no command taken while a detect sweep is still sending rows
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
    else $error("command accepted in the middle of a detect sweep");

    // error beats close their command and carry no hits
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != sbct_pkg::STAT_OK) |-> m_tlast && (m_tdata[20:5] == 16'd0))
    else $error("error beat with hits or without tlast");

    // table full reports a full count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sbct_pkg::STAT_FULL)
        |-> (m_tdata[25:21] == 5'(SLOTS)) && !m_tdata[4])
    else $error("table full reported with free slots");

    // hits only on lower slots, none for an empty row
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (SLOTS <= 16)
        |-> ((m_tdata[20:5] >> m_tdata[3:0]) == 16'd0) && (m_tdata[4] || m_tdata[20:5] == 16'd0))
    else $error("hit mask names a slot that is not lower or row is empty");

endmodule

bind square_box_collision_table sbct_checker #(.SLOTS(SLOTS)) u_sbct_checker (.*);

`default_nettype wire
